>>> hw/rtl/swrm_pkg.sv
// ============================================================================
// swrm_pkg: shared types and constants of the sliding-window rate meter
// Field widths, history depth and the layout of one stored history entry.
// ============================================================================
package swrm_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int PTR_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  localparam int TIME_W   = 48;
  localparam int WINDOW_W = 40;
  localparam int EVENT_W  = 32;
  localparam int COST_W   = 32;
  localparam int TOTAL_W  = 38;
  localparam int ENTRY_W  = 7;
  localparam int SUM_W    = EVENT_W + CNT_W;

  localparam int MIN_ENTRIES = 3;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(180000000);
  localparam logic [63:0]         TOTAL_MAX    = (64'd1 << TOTAL_W) - 64'd1;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]  start_us;
    logic [COST_W-1:0]  cost;
    logic [EVENT_W-1:0] events;
  } hist_entry_t;

  localparam int HIST_W = $bits(hist_entry_t);

endpackage

>>> hw/rtl/swrm_ram.sv
// ============================================================================
// swrm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module swrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/sliding_window_rate_meter_core.sv
// ============================================================================
// sliding_window_rate_meter_core: sliding time window throughput meter
// Keeps a history queue of samples in RAM and forms a rate over a window.
// ============================================================================
// Usage
//   Input items (operation, now_us, event_count, cost_us) are offered with
//   in_valid and taken when in_stall is low. A record item evicts aged entries
//   from the head of the queue, appends the new sample and, once at least
//   three entries are held, refreshes the rate cache. A clear item empties
//   the queue and returns the cache to idle.
//   Every item produces exactly one result item on the out_valid/out_stall
//   channel, held in an output register until it is taken.
//   A record item passes through S_START, S_WIN, S_CHECK, S_APPEND, S_FINAL
//   and S_DONE, staying in S_CHECK while entries are evicted by age (one per
//   cycle); a clear item goes straight to S_DONE. The result register is loaded
//   from S_DONE, which then returns to S_IDLE. The sequencer runs one saturating
//   48-bit subtractor three times per record and walks the head of the history
//   RAM one entry per cycle. in_stall is high while an item is in progress.
//   A new item is accepted while an earlier result still waits; if the
//   receiver stalls, the next item finishes and then waits for the output
//   register to free.
//   cfg_write loads window_us from cfg_data; write only while idle.
//   Reset is synchronous: the queue is empty, the cache is idle with zeros,
//   window_us returns to 180000000 and no result is pending.
// ============================================================================
module sliding_window_rate_meter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [swrm_pkg::WINDOW_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [swrm_pkg::TIME_W-1:0]    now_us,
  input  logic [swrm_pkg::EVENT_W-1:0]   event_count,
  input  logic [swrm_pkg::COST_W-1:0]    cost_us,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           idle,
  output logic [swrm_pkg::TOTAL_W-1:0]   events_total,
  output logic [swrm_pkg::TOTAL_W-1:0]   cost_total,
  output logic [swrm_pkg::TIME_W-1:0]    window_len_us,
  output logic                           overflowed,
  output logic [swrm_pkg::ENTRY_W-1:0]   entries
);

  import swrm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WIN,
    S_CHECK,
    S_APPEND,
    S_FINAL,
    S_DONE
  } state_t;

  state_t state;

  logic [WINDOW_W-1:0] window_us;
  logic [TIME_W-1:0]   now_r;
  logic [EVENT_W-1:0]  events_r;
  logic [COST_W-1:0]   cost_r;
  logic [TIME_W-1:0]   start_r;
  logic [TIME_W-1:0]   win_start;
  logic                mature;
  logic                drop_full;

  logic [PTR_W-1:0] head_ptr;
  logic [CNT_W-1:0] entry_count;
  logic [SUM_W-1:0] sum_events;
  logic [SUM_W-1:0] sum_cost;

  logic                cache_idle;
  logic [TOTAL_W-1:0]  cache_events;
  logic [TOTAL_W-1:0]  cache_cost;
  logic [TIME_W-1:0]   cache_window;

  logic        in_take;
  logic        out_take;
  logic        out_load;
  hist_entry_t head_entry;
  hist_entry_t new_entry;
  logic [HIST_W-1:0] rd_data;

  logic evict_age;
  logic evict_full;
  logic head_drop;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail_ptr;
  logic             ram_we;

  logic [TIME_W-1:0] sub_a;
  logic [TIME_W-1:0] sub_b;
  logic [TIME_W-1:0] sub_res;

  logic [TOTAL_W-1:0] sat_events;
  logic [TOTAL_W-1:0] sat_cost;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_load = (state == S_DONE) && (!out_valid || out_take);

  assign head_entry = hist_entry_t'(rd_data);
  assign new_entry  = '{start_us: start_r, cost: cost_r, events: events_r};

  // The one shared saturating subtractor, steered by the sequencer.
  always_comb begin
    case (state)
      S_START: begin
        sub_a = now_r;
        sub_b = TIME_W'(cost_r);
      end
      S_WIN: begin
        sub_a = now_r;
        sub_b = TIME_W'(window_us);
      end
      default: begin
        sub_a = now_r;
        sub_b = head_entry.start_us;
      end
    endcase
    sub_res = (sub_a > sub_b) ? (sub_a - sub_b) : '0;
  end

  assign evict_age  = (state == S_CHECK) && (entry_count != '0) &&
                      (head_entry.start_us < win_start);
  assign evict_full = (state == S_CHECK) && !evict_age &&
                      (entry_count == CNT_W'(HISTORY_DEPTH));
  assign head_drop  = evict_age || evict_full;

  assign head_inc = (head_ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head_ptr + 1'b1;

  // The RAM is read at the next head so that its data always follows head_ptr.
  always_comb begin
    head_next = head_ptr;
    if (in_take && (operation == OP_CLEAR)) begin
      head_next = '0;
    end else if (head_drop) begin
      head_next = head_inc;
    end
  end

  always_comb begin
    tail_sum = {1'b0, head_ptr} + (PTR_W + 1)'(entry_count);
    if (tail_sum >= (PTR_W + 1)'(HISTORY_DEPTH)) begin
      tail_sum = tail_sum - (PTR_W + 1)'(HISTORY_DEPTH);
    end
    tail_ptr = tail_sum[PTR_W-1:0];
  end

  assign ram_we = (state == S_APPEND);

  assign sat_events = (64'(sum_events) > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0]
                                                   : TOTAL_W'(sum_events);
  assign sat_cost   = (64'(sum_cost) > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0]
                                                 : TOTAL_W'(sum_cost);

  swrm_ram #(
    .WIDTH (HIST_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_ptr),
    .wdata (new_entry),
    .raddr (head_next),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      window_us    <= WINDOW_RESET;
      head_ptr     <= '0;
      entry_count  <= '0;
      sum_events   <= '0;
      sum_cost     <= '0;
      cache_idle   <= 1'b1;
      cache_events <= '0;
      cache_cost   <= '0;
      cache_window <= '0;
      mature       <= 1'b0;
      drop_full    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        window_us <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      head_ptr <= head_next;

      case (state)
        S_IDLE: begin
          if (in_take) begin
            now_r     <= now_us;
            events_r  <= event_count;
            cost_r    <= cost_us;
            mature    <= 1'b0;
            drop_full <= 1'b0;
            if (operation == OP_CLEAR) begin
              entry_count  <= '0;
              sum_events   <= '0;
              sum_cost     <= '0;
              cache_idle   <= 1'b1;
              cache_events <= '0;
              cache_cost   <= '0;
              cache_window <= '0;
              state        <= S_DONE;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          start_r <= sub_res;
          state   <= S_WIN;
        end
        S_WIN: begin
          win_start <= sub_res;
          state     <= S_CHECK;
        end
        S_CHECK: begin
          if (head_drop) begin
            sum_events  <= sum_events - SUM_W'(head_entry.events);
            sum_cost    <= sum_cost - SUM_W'(head_entry.cost);
            entry_count <= entry_count - 1'b1;
          end
          if (evict_age) begin
            mature <= 1'b1;
          end else begin
            drop_full <= evict_full;
            state     <= S_APPEND;
          end
        end
        S_APPEND: begin
          sum_events  <= sum_events + SUM_W'(events_r);
          sum_cost    <= sum_cost + SUM_W'(cost_r);
          entry_count <= entry_count + 1'b1;
          state       <= S_FINAL;
        end
        S_FINAL: begin
          if (entry_count >= CNT_W'(MIN_ENTRIES)) begin
            cache_idle   <= 1'b0;
            cache_events <= sat_events;
            cache_cost   <= sat_cost;
            cache_window <= mature ? TIME_W'(window_us) : sub_res;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            idle          <= cache_idle;
            events_total  <= cache_events;
            cost_total    <= cache_cost;
            window_len_us <= cache_window;
            overflowed    <= drop_full;
            entries       <= ENTRY_W'(entry_count);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
